// ----- hdl/shap_pkg.sv -----
// Shared types, widths and codes for the shift-and pattern hit matcher.
package shap_pkg;

   localparam int PATTERN_BITS_DEF  = 30;
   localparam int ALPHABET_SIZE_DEF = 256;
   localparam int POSITION_BITS_DEF = 24;

   localparam int MASK_W    = 30;
   localparam int HITS_W    = 16;
   localparam int POS_W     = 24;
   localparam int LETTER_W  = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 30;

   localparam logic [HITS_W-1:0] MAX_HITS_RESET = 16'd10000;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_RESIDUE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_END_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HITS = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [LETTER_W-1:0] letter;
      logic [MASK_W-1:0]   position_bits;
      logic                first_residue;
      logic                last_residue;
   } shap_req_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] end_pos;
      logic [POS_W-1:0] start_pos;
      logic             limit_reached;
      logic             sequence_done;
   } shap_rsp_type;

endpackage

// ----- hdl/shap_cell.sv -----
// One bit of the shift-and match vector; takes its shifted bit from the lower neighbor.
module shap_cell (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic clr,
   input  logic carry_in,
   input  logic mask_prev,
   input  logic mask_bit,
   input  logic entry_bit,
   output logic carry_out,
   output logic common
);
   logic v_ff;
   logic v_in;

   // new sequence: this bit no longer feeds the neighbor above
   assign carry_out = v_ff & ~clr;
   assign v_in      = (carry_in | mask_prev) & entry_bit;
   assign common    = v_in & mask_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end
endmodule

// ----- hdl/shap_span.sv -----
// Span of a hit and its start position from the common bits and the end mask.
module shap_span #(
   parameter int PATTERN_BITS  = shap_pkg::PATTERN_BITS_DEF,
   parameter int POSITION_BITS = shap_pkg::POSITION_BITS_DEF
) (
   input  logic [PATTERN_BITS-1:0]  common,
   input  logic [PATTERN_BITS-1:0]  mask,
   input  logic [POSITION_BITS-1:0] end_pos,
   output logic [POSITION_BITS-1:0] start_pos
);
   localparam int IW = $clog2(PATTERN_BITS);
   localparam int SW = $clog2(PATTERN_BITS + 1);
   localparam int EW = POSITION_BITS + 1;

   logic [PATTERN_BITS-1:0] low;
   logic [PATTERN_BITS-1:0] below;
   logic [IW-1:0]           p;
   logic [IW-1:0]           q;
   logic                    found;
   logic [SW-1:0]           span;
   logic [EW-1:0]           end1;
   logic [EW-1:0]           span_ext;

   always_comb begin
      low   = common & (~common + PATTERN_BITS'(1));
      below = mask & (low - PATTERN_BITS'(1));
      p     = '0;
      q     = '0;
      found = 1'b0;
      for (int i = 0; i < PATTERN_BITS; i++) begin
         if (low[i]) begin
            p = p | IW'(i);
         end
         // ascending scan, the highest set bit wins
         if (below[i]) begin
            q     = IW'(i);
            found = 1'b1;
         end
      end
      span     = found ? (SW'(p) - SW'(q)) : (SW'(p) + SW'(1));
      end1     = EW'(end_pos) + EW'(1);
      span_ext = EW'(span);
      start_pos = (span_ext > end1) ? '0 : POSITION_BITS'(end1 - span_ext);
   end
endmodule

// ----- hdl/shift_and_pattern_hits.sv -----
// Top level of the shift-and pattern hit matcher: table, cell row and output stage.
//
//   channel   ports                                   direction
//   request   req_valid  req_stall  req_data           in  (load or residue)
//   response  rsp_valid  rsp_stall  rsp_data           out (one beat per residue)
//   config    csr_we  csr_index  csr_wdata             in  (write only)
//
// One beat per cycle unless rsp stalls. A residue reaches its result beat via letter
// table read, cell row update, span/start and output register. A load gives no result.
// Reset clears the match vector, counters and pipeline; the letter table is not cleared.
// A stall on rsp holds each full stage; empty stages still fill, so the request side
// stalls only once all three are full.
module shift_and_pattern_hits #(
   parameter int PATTERN_BITS  = shap_pkg::PATTERN_BITS_DEF,
   parameter int ALPHABET_SIZE = shap_pkg::ALPHABET_SIZE_DEF,
   parameter int POSITION_BITS = shap_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  shap_pkg::shap_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output shap_pkg::shap_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [shap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [shap_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import shap_pkg::*;

   localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam logic [LETTER_W:0] ALPHA_LIM = (LETTER_W + 1)'(ALPHABET_SIZE);

   // configuration
   logic [MASK_W-1:0] end_mask_ff;
   logic [HITS_W-1:0] max_hits_ff;
   logic [PATTERN_BITS-1:0] mask;

   // letter table
   logic [PATTERN_BITS-1:0] letter_mem [ALPHABET_SIZE];
   logic [PATTERN_BITS-1:0] entry_ff;

   // stage 1: table read
   logic s1_valid_ff, s1_valid_in;
   logic s1_first_ff, s1_last_ff, s1_inrange_ff;

   // stage 2: match vector updated
   logic s2_valid_ff, s2_valid_in;
   logic s2_hit_ff, s2_stop_ff, s2_last_ff;
   logic [POSITION_BITS-1:0] s2_end_ff;
   logic [PATTERN_BITS-1:0]  s2_common_ff;

   // sequence counters
   logic [POSITION_BITS-1:0] ri_ff, ri_in, ri_eff;
   logic [HITS_W-1:0]        hc_ff, hc_in, hc_eff, hit_limit;
   logic                     stopped_ff, stopped_in, stop_eff, hit_new;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   shap_rsp_type rsp_data_ff;

   logic accept, res_acc, load_acc, in_range;
   logic out_ready, s2_ready, s1_ready, s1_go, s2_go;
   logic [AW-1:0] letter_idx;
   logic [PATTERN_BITS-1:0] entry_eff, mask_sh, chain_in, chain_out, common;
   logic [POSITION_BITS-1:0] start_calc;

   assign mask       = PATTERN_BITS'(end_mask_ff);
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s1_go      = s1_valid_ff && s2_ready;
   assign s2_go      = s2_valid_ff && out_ready;
   assign req_stall  = !s1_ready;
   assign accept     = req_valid && !req_stall;
   assign res_acc    = accept && (req_data.opcode == OP_RESIDUE);
   assign load_acc   = accept && (req_data.opcode == OP_LOAD);
   assign in_range   = {1'b0, req_data.letter} < ALPHA_LIM;
   assign letter_idx = AW'(req_data.letter);

   always_ff @(posedge clock) begin
      if (reset) begin
         end_mask_ff <= '0;
         max_hits_ff <= MAX_HITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_END_MASK: end_mask_ff <= csr_wdata;
            CSR_MAX_HITS: max_hits_ff <= csr_wdata[HITS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && in_range) begin
         letter_mem[letter_idx] <= PATTERN_BITS'(req_data.position_bits);
      end
      if (res_acc) begin
         entry_ff <= letter_mem[letter_idx];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (res_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (res_acc) begin
         s1_first_ff   <= req_data.first_residue;
         s1_last_ff    <= req_data.last_residue;
         s1_inrange_ff <= in_range;
      end
   end

   // cell row: bit 0 always takes the seed one
   assign entry_eff = s1_inrange_ff ? entry_ff : '0;
   assign mask_sh   = {mask[PATTERN_BITS-2:0], 1'b0};
   assign chain_in  = {chain_out[PATTERN_BITS-2:0], 1'b1};

   for (genvar i = 0; i < PATTERN_BITS; i++) begin : g_cell
      shap_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (s1_go),
         .clr       (s1_first_ff),
         .carry_in  (chain_in[i]),
         .mask_prev (mask_sh[i]),
         .mask_bit  (mask[i]),
         .entry_bit (entry_eff[i]),
         .carry_out (chain_out[i]),
         .common    (common[i])
      );
   end

   always_comb begin
      ri_eff    = s1_first_ff ? '0 : ri_ff;
      hc_eff    = s1_first_ff ? '0 : hc_ff;
      stop_eff  = s1_first_ff ? 1'b0 : stopped_ff;
      hit_limit = (max_hits_ff == '0) ? HITS_W'(1) : max_hits_ff;
      hit_new   = (|common) && !stop_eff;
      hc_in     = (hit_new && (hc_eff != '1)) ? hc_eff + HITS_W'(1) : hc_eff;
      stopped_in = stop_eff || (hit_new && (hc_in >= hit_limit));
      ri_in     = (ri_eff == '1) ? ri_eff : ri_eff + POSITION_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff      <= '0;
         hc_ff      <= '0;
         stopped_ff <= 1'b0;
      end else if (s1_go) begin
         ri_ff      <= ri_in;
         hc_ff      <= hc_in;
         stopped_ff <= stopped_in;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_go) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_go) begin
         s2_hit_ff    <= hit_new;
         s2_stop_ff   <= stopped_in;
         s2_last_ff   <= s1_last_ff;
         s2_end_ff    <= ri_eff;
         s2_common_ff <= common;
      end
   end

   shap_span #(
      .PATTERN_BITS  (PATTERN_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_span (
      .common    (s2_common_ff),
      .mask      (mask),
      .end_pos   (s2_end_ff),
      .start_pos (start_calc)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s2_go) begin
         rsp_data_ff.hit           <= s2_hit_ff;
         rsp_data_ff.end_pos       <= POS_W'(s2_end_ff);
         rsp_data_ff.start_pos     <= s2_hit_ff ? POS_W'(start_calc) : '0;
         rsp_data_ff.limit_reached <= s2_stop_ff;
         rsp_data_ff.sequence_done <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ----- hdl/shap_checker.sv -----
// Port-level checks for the shift-and pattern hit matcher, bound to the top level.
module shap_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input shap_pkg::shap_rsp_type rsp_data
);
   import shap_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   // a match cannot start after it ends
   a_start_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.start_pos <= rsp_data.end_pos)
      else $error("start_pos beyond end_pos");

   // no start position without a hit
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.start_pos == '0)
      else $error("start_pos set without hit");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");
endmodule

bind shift_and_pattern_hits shap_checker u_shap_checker (.*);
